// ----- design/grp_pkg.sv -----
// Shared types and constants of the guillotine rectangle packer.
package grp_pkg;

    localparam int COORD_W = 13;
    localparam int SIZE_W  = 14;

    // Largest buffer dimension; register writes above it are clamped to it.
    localparam logic [SIZE_W-1:0] MAX_BUF = 14'd8192;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_BUFFER_WIDTH  = 2'd0;
    localparam cfg_index_t CFG_BUFFER_HEIGHT = 2'd1;

    // One free rectangle of the list.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
    } rect_t;

endpackage

// ----- design/guillotine_rect_packer.sv -----
// Top level of the guillotine first-fit rectangle packer with its free-list memory.
//
// Usage: a request (s_request_width, s_request_height) enters on a valid/ready channel and
// one result (m_place_x, m_place_y, m_page_index, m_page_flipped, m_oversize_error) leaves
// on a valid/ready channel for every request. The block takes one request at a time:
// s_ready is high only while the sequencer is idle.
// Steps: an oversized request goes straight to its result. Otherwise the first-fit scan reads one
// free entry per cycle through the single memory read port, the sequencer plans the split
// (planning once more when the pieces would overflow the list and the page flips), the
// entries behind the chosen one shift by one slot per cycle when the list grows or shrinks,
// the WR0 and WR1 steps write the new pieces and the last step loads the result.
// The shared memory port, one read and one write a cycle, paces the scan and the shift.
// A finished result sits in an output register; a stalled receiver holds it there. The
// block still takes the next request and works on it, but holds in its last step until
// that register has been passed on.
// Reset (aresetn, synchronous, active low) sets the buffer to 256 x 256, page 0 and a free
// list holding the whole buffer; it needs no clearing pass. A write on the configuration port
// (cfg_we, cfg_index, cfg_wdata), allowed only while idle, sets buffer width (index 0) or
// height (index 1), clamped to 8192, and resets the free list to the new whole buffer.
module guillotine_rect_packer #(
    parameter int FREE_LIST_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  grp_pkg::cfg_index_t cfg_index,
    input  logic [13:0]         cfg_wdata,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [13:0]         s_request_width,
    input  logic [13:0]         s_request_height,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [12:0]         m_place_x,
    output logic [12:0]         m_place_y,
    output logic                m_page_index,
    output logic                m_page_flipped,
    output logic                m_oversize_error
);
    import grp_pkg::*;

    localparam int AW = $clog2(FREE_LIST_DEPTH);
    localparam int CW = $clog2(FREE_LIST_DEPTH + 1);
    localparam logic [CW:0] LIST_LIMIT = (CW+1)'(FREE_LIST_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_PLAN = 3'd2;
    localparam logic [2:0] ST_MOVE = 3'd3;
    localparam logic [2:0] ST_WR0  = 3'd4;
    localparam logic [2:0] ST_WR1  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // free-list memory, one write and one registered read a cycle
    rect_t mem [FREE_LIST_DEPTH];
    rect_t rd_data_reg;
    logic  mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    rect_t mem_wd;

    // control state
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          base_reg, base_next;     // entry 0 reads as the whole buffer
    logic          rd_base_reg, rd_base_next;
    logic          page_reg, page_next;
    logic [13:0]   bw_reg, bw_next, bh_reg, bh_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [CW-1:0] mv_src_reg, mv_src_next, mv_dst_reg, mv_dst_next;
    logic [CW-1:0] mv_left_reg, mv_left_next;
    logic          mv_pend_reg, mv_pend_next, mv_down_reg, mv_down_next;
    logic          m_valid_reg, m_valid_next;

    // payload
    logic [13:0]   req_w_reg, req_w_next, req_h_reg, req_h_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next, idx_reg, idx_next;
    rect_t         ent_reg, ent_next, p0_reg, p0_next, p1_reg, p1_next;
    logic [1:0]    np_reg, np_next;
    logic [12:0]   res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic          res_flip_reg, res_flip_next, res_err_reg, res_err_next;
    logic [12:0]   m_x_reg, m_x_next, m_y_reg, m_y_next;
    logic          m_page_reg, m_page_next, m_flip_reg, m_flip_next, m_err_reg, m_err_next;

    // datapath helpers
    rect_t         whole, rd_ent, fst, sec;
    logic [13:0]   cfg_val, ww, hh, x_plus_w, y_plus_h;
    logic          fit, split, fst_ok, sec_ok, ovf;
    logic [1:0]    n_pieces;

    assign whole  = '{x: '0, y: '0, w: bw_reg, h: bh_reg};
    assign rd_ent = rd_base_reg ? whole : rd_data_reg;
    assign cfg_val = (cfg_wdata > MAX_BUF) ? MAX_BUF : cfg_wdata;
    assign fit = chk_valid_reg && (rd_ent.w >= req_w_reg) && (rd_ent.h >= req_h_reg);

    // split planner for the chosen entry
    always_comb begin
        ww       = ent_reg.w - req_w_reg;
        hh       = ent_reg.h - req_h_reg;
        x_plus_w = {1'b0, ent_reg.x} + {1'b0, req_w_reg[12:0]};
        y_plus_h = {1'b0, ent_reg.y} + {1'b0, req_h_reg[12:0]};
        split    = |(ww[13:1] | hh[13:1]);
        if (ww >= hh) begin
            fst = '{x: x_plus_w[12:0], y: ent_reg.y, w: ww, h: ent_reg.h};
            sec = '{x: ent_reg.x, y: y_plus_h[12:0], w: req_w_reg, h: hh};
        end else begin
            fst = '{x: ent_reg.x, y: y_plus_h[12:0], w: ent_reg.w, h: hh};
            sec = '{x: x_plus_w[12:0], y: ent_reg.y, w: ww, h: req_h_reg};
        end
        sec_ok   = split && (sec.w != '0) && (sec.h != '0);
        fst_ok   = split && (fst.w != '0) && (fst.h != '0);
        n_pieces = {1'b0, sec_ok} + {1'b0, fst_ok};
        ovf      = ({1'b0, cnt_reg} + (CW+1)'(n_pieces)) > LIST_LIMIT;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        base_next      = base_reg;
        page_next      = page_reg;
        bw_next        = bw_reg;
        bh_next        = bh_reg;
        iss_next       = iss_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        mv_src_next    = mv_src_reg;
        mv_dst_next    = mv_dst_reg;
        mv_left_next   = mv_left_reg;
        mv_pend_next   = mv_pend_reg;
        mv_down_next   = mv_down_reg;
        m_valid_next   = m_valid_reg;
        req_w_next     = req_w_reg;
        req_h_next     = req_h_reg;
        idx_next       = idx_reg;
        ent_next       = ent_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        np_next        = np_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_flip_next  = res_flip_reg;
        res_err_next   = res_err_reg;
        m_x_next       = m_x_reg;
        m_y_next       = m_y_reg;
        m_page_next    = m_page_reg;
        m_flip_next    = m_flip_reg;
        m_err_next     = m_err_reg;
        mem_we         = 1'b0;
        mem_wa         = idx_reg;
        mem_wd         = p0_reg;
        mem_ra         = iss_reg[AW-1:0];

        // drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // configuration: set the size and reset the list to the whole buffer
        if (cfg_we && (cfg_index == CFG_BUFFER_WIDTH || cfg_index == CFG_BUFFER_HEIGHT)) begin
            if (cfg_index == CFG_BUFFER_WIDTH) begin
                bw_next = cfg_val;
            end else begin
                bh_next = cfg_val;
            end
            cnt_next  = CW'(1);
            base_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_w_next    = s_request_width;
                    req_h_next    = s_request_height;
                    res_flip_next = 1'b0;
                    res_x_next    = '0;
                    res_y_next    = '0;
                    if (s_request_width > bw_reg || s_request_height > bh_reg) begin
                        res_err_next = 1'b1;
                        state_next   = ST_DONE;
                    end else begin
                        res_err_next   = 1'b0;
                        iss_next       = '0;
                        chk_valid_next = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (fit) begin
                    ent_next   = rd_ent;
                    idx_next   = chk_idx_reg;
                    state_next = ST_PLAN;
                end else if (iss_reg < cnt_reg) begin
                    // issue the next read; check it next cycle
                    chk_valid_next = 1'b1;
                    chk_idx_next   = iss_reg[AW-1:0];
                    iss_next       = iss_reg + CW'(1);
                end else begin
                    // nothing fits: flip page, restart from the whole buffer
                    page_next     = ~page_reg;
                    cnt_next      = CW'(1);
                    base_next     = 1'b1;
                    res_flip_next = 1'b1;
                    ent_next      = whole;
                    idx_next      = '0;
                    state_next    = ST_PLAN;
                end
            end
            ST_PLAN: begin
                if (ovf) begin
                    page_next     = ~page_reg;
                    cnt_next      = CW'(1);
                    base_next     = 1'b1;
                    res_flip_next = 1'b1;
                    ent_next      = whole;
                    idx_next      = '0;
                end else begin
                    np_next      = n_pieces;
                    p0_next      = sec_ok ? sec : fst;
                    p1_next      = fst;
                    res_x_next   = ent_reg.x;
                    res_y_next   = ent_reg.y;
                    mv_pend_next = 1'b0;
                    mv_down_next = (n_pieces == 2'd0);
                    mv_left_next = (n_pieces == 2'd1) ? '0
                                 : CW'(cnt_reg - CW'(1) - CW'(idx_reg));
                    mv_src_next  = (n_pieces == 2'd0) ? CW'(CW'(idx_reg) + CW'(1))
                                 : CW'(cnt_reg - CW'(1));
                    state_next   = ST_MOVE;
                end
            end
            ST_MOVE: begin
                // write the entry read last cycle to its new slot
                if (mv_pend_reg) begin
                    mem_we = 1'b1;
                    mem_wa = mv_dst_reg[AW-1:0];
                    mem_wd = rd_ent;
                end
                if (mv_left_reg != '0) begin
                    mem_ra       = mv_src_reg[AW-1:0];
                    mv_pend_next = 1'b1;
                    mv_dst_next  = mv_down_reg ? mv_src_reg - CW'(1) : mv_src_reg + CW'(1);
                    mv_src_next  = mv_down_reg ? mv_src_reg + CW'(1) : mv_src_reg - CW'(1);
                    mv_left_next = mv_left_reg - CW'(1);
                end else begin
                    mv_pend_next = 1'b0;
                    state_next   = ST_WR0;
                end
            end
            ST_WR0: begin
                mem_we     = (np_reg != 2'd0);
                mem_wa     = idx_reg;
                mem_wd     = p0_reg;
                state_next = ST_WR1;
            end
            ST_WR1: begin
                mem_we     = (np_reg == 2'd2);
                mem_wa     = idx_reg + AW'(1);
                mem_wd     = p1_reg;
                cnt_next   = CW'(cnt_reg - CW'(1) + CW'(np_reg));
                base_next  = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_x_next     = res_x_reg;
                    m_y_next     = res_y_reg;
                    m_page_next  = page_reg;
                    m_flip_next  = res_flip_reg;
                    m_err_next   = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        rd_base_next = base_reg && (mem_ra == '0);
    end

    // free-list memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= CW'(1);
            base_reg      <= 1'b1;
            rd_base_reg   <= 1'b0;
            page_reg      <= 1'b0;
            bw_reg        <= 14'd256;
            bh_reg        <= 14'd256;
            iss_reg       <= '0;
            chk_valid_reg <= 1'b0;
            mv_src_reg    <= '0;
            mv_dst_reg    <= '0;
            mv_left_reg   <= '0;
            mv_pend_reg   <= 1'b0;
            mv_down_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            base_reg      <= base_next;
            rd_base_reg   <= rd_base_next;
            page_reg      <= page_next;
            bw_reg        <= bw_next;
            bh_reg        <= bh_next;
            iss_reg       <= iss_next;
            chk_valid_reg <= chk_valid_next;
            mv_src_reg    <= mv_src_next;
            mv_dst_reg    <= mv_dst_next;
            mv_left_reg   <= mv_left_next;
            mv_pend_reg   <= mv_pend_next;
            mv_down_reg   <= mv_down_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_w_reg    <= req_w_next;
        req_h_reg    <= req_h_next;
        chk_idx_reg  <= chk_idx_next;
        idx_reg      <= idx_next;
        ent_reg      <= ent_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        np_reg       <= np_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_flip_reg <= res_flip_next;
        res_err_reg  <= res_err_next;
        m_x_reg      <= m_x_next;
        m_y_reg      <= m_y_next;
        m_page_reg   <= m_page_next;
        m_flip_reg   <= m_flip_next;
        m_err_reg    <= m_err_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_place_x        = m_x_reg;
    assign m_place_y        = m_y_reg;
    assign m_page_index     = m_page_reg;
    assign m_page_flipped   = m_flip_reg;
    assign m_oversize_error = m_err_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(FREE_LIST_DEPTH))
        else $error("free list count above depth");

    a_base_single: assert property (@(posedge aclk) disable iff (!aresetn)
        base_reg |-> (cnt_reg == CW'(1)))
        else $error("whole-buffer entry with more than one list entry");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in flight");

    a_oversize_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_oversize_error) |->
            (!m_page_flipped && m_place_x == '0 && m_place_y == '0))
        else $error("oversize result carries a placement");

    a_plan_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PLAN) |-> (ent_reg.w >= req_w_reg && ent_reg.h >= req_h_reg))
        else $error("chosen free entry smaller than request");
`endif

endmodule
